@@ src/pcm_pkg.sv @@
// ---------------------------------------------------------------------------
// pcm_pkg: shared types and constants for the particle color map
// widths, speed band limits, ramp codes and ramp endpoint colors
// ---------------------------------------------------------------------------
package pcm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VEL_W         = 24;
    localparam int DENS_W        = 32;
    localparam int CH_W          = 8;
    localparam int SQ_W          = 2 * VEL_W;
    localparam int ROOT_W        = VEL_W;
    localparam int RAMP_W        = 3;
    localparam int CFG_IDX_W     = 1;

    // speed band limits in Q16.8
    localparam logic [ROOT_W-1:0] SPEED_100 = 24'd25600;
    localparam logic [ROOT_W-1:0] SPEED_300 = 24'd76800;
    localparam logic [ROOT_W-1:0] SPEED_400 = 24'd102400;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'd1;

    // color ramps
    localparam logic [RAMP_W-1:0] RAMP_SLOW  = 3'd0;
    localparam logic [RAMP_W-1:0] RAMP_MID   = 3'd1;
    localparam logic [RAMP_W-1:0] RAMP_FAST  = 3'd2;
    localparam logic [RAMP_W-1:0] RAMP_SAND  = 3'd3;
    localparam logic [RAMP_W-1:0] RAMP_BROWN = 3'd4;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        t_rgb lo;
        t_rgb hi;
    } t_ramp;

    function automatic t_ramp ramp_colors(input logic [RAMP_W-1:0] code);
        t_ramp c;
        case (code)
            RAMP_SLOW: begin
                c.lo = '{8'd213, 8'd196, 8'd166};
                c.hi = '{8'd114, 8'd43, 8'd106};
            end
            RAMP_MID: begin
                c.lo = '{8'd114, 8'd43, 8'd106};
                c.hi = '{8'd162, 8'd38, 8'd75};
            end
            RAMP_FAST: begin
                c.lo = '{8'd162, 8'd38, 8'd75};
                c.hi = '{8'd211, 8'd33, 8'd45};
            end
            RAMP_SAND: begin
                c.lo = '{8'd200, 8'd186, 8'd126};
                c.hi = '{8'd157, 8'd193, 8'd131};
            end
            default: begin
                c.lo = '{8'd73, 8'd57, 8'd44};
                c.hi = '{8'd157, 8'd193, 8'd131};
            end
        endcase
        return c;
    endfunction

endpackage

@@ src/pcm_sqrt_pipe.sv @@
// ---------------------------------------------------------------------------
// pcm_sqrt_pipe: pipelined integer square root
// one root bit per stage, floor of the root of a 48-bit radicand
// ---------------------------------------------------------------------------
module pcm_sqrt_pipe #(
    parameter int SIDE_W = pcm_pkg::DENS_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [pcm_pkg::SQ_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [pcm_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int STEPS = pcm_pkg::ROOT_W;
    localparam int REM_W = pcm_pkg::ROOT_W + 2;
    localparam int CUR_W = REM_W + 2;

    logic                       r_valid [STEPS];
    logic [REM_W-1:0]           r_rem   [STEPS];
    logic [pcm_pkg::ROOT_W-1:0] r_root  [STEPS];
    logic [pcm_pkg::SQ_W-1:0]   r_rad   [STEPS];
    logic [SIDE_W-1:0]          r_side  [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic                       s_valid;
        logic [REM_W-1:0]           s_rem;
        logic [pcm_pkg::ROOT_W-1:0] s_root;
        logic [pcm_pkg::SQ_W-1:0]   s_rad;
        logic [SIDE_W-1:0]          s_side;
        logic [CUR_W-1:0]           cur;
        logic [CUR_W-1:0]           trial;
        logic [REM_W-1:0]           n_rem;
        logic [pcm_pkg::ROOT_W-1:0] n_root;

        if (g == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_rem   = '0;
            assign s_root  = '0;
            assign s_rad   = i_rad;
            assign s_side  = i_side;
        end else begin : g_next
            assign s_valid = r_valid[g-1];
            assign s_rem   = r_rem[g-1];
            assign s_root  = r_root[g-1];
            assign s_rad   = r_rad[g-1];
            assign s_side  = r_side[g-1];
        end

        always_comb begin
            cur   = {s_rem, s_rad[pcm_pkg::SQ_W-1 -: 2]};
            trial = {2'b00, s_root, 2'b01};
            if (cur >= trial) begin
                n_rem  = REM_W'(cur - trial);
                n_root = {s_root[pcm_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(cur);
                n_root = {s_root[pcm_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= s_valid;
            end
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_rad[g]  <= {s_rad[pcm_pkg::SQ_W-3:0], 2'b00};
                r_side[g] <= s_side;
            end
        end
    end

    assign o_valid = r_valid[STEPS-1];
    assign o_root  = r_root[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

@@ src/pcm_div_pipe.sv @@
// ---------------------------------------------------------------------------
// pcm_div_pipe: pipelined fraction divider
// floor(num * 2^FRAC_BITS / den) for num <= den, one quotient bit per stage
// ---------------------------------------------------------------------------
module pcm_div_pipe #(
    parameter int FRAC_BITS = pcm_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = pcm_pkg::RAMP_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [pcm_pkg::DENS_W-1:0] i_num,
    input  logic [pcm_pkg::DENS_W-1:0] i_den,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [FRAC_BITS:0]         o_quot,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int W     = pcm_pkg::DENS_W;

    logic             r_valid [STEPS];
    logic [W-1:0]     r_rem   [STEPS];
    logic [W-1:0]     r_den   [STEPS];
    logic [FRAC_BITS:0] r_quot [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic               s_valid;
        logic [W:0]         cur;
        logic [W-1:0]       s_den;
        logic [FRAC_BITS:0] s_quot;
        logic [SIDE_W-1:0]  s_side;
        logic [W-1:0]       n_rem;
        logic               n_bit;

        if (g == 0) begin : g_first
            assign s_valid = i_valid;
            assign cur     = {1'b0, i_num};
            assign s_den   = i_den;
            assign s_quot  = '0;
            assign s_side  = i_side;
        end else begin : g_next
            assign s_valid = r_valid[g-1];
            assign cur     = {r_rem[g-1], 1'b0};
            assign s_den   = r_den[g-1];
            assign s_quot  = r_quot[g-1];
            assign s_side  = r_side[g-1];
        end

        always_comb begin
            n_bit = (cur >= {1'b0, s_den});
            if (n_bit) begin
                n_rem = W'(cur - {1'b0, s_den});
            end else begin
                n_rem = W'(cur);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= s_valid;
            end
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_den[g]  <= s_den;
                r_quot[g] <= {s_quot[FRAC_BITS-1:0], n_bit};
                r_side[g] <= s_side;
            end
        end
    end

    assign o_valid = r_valid[STEPS-1];
    assign o_quot  = r_quot[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

@@ src/particle_color_map_top.sv @@
// ---------------------------------------------------------------------------
// particle_color_map_top: particle color ramp
// maps a particle's speed or density ratio to an rgb word
// ---------------------------------------------------------------------------
// One word in, one rgb word out, fully pipelined: a new word is taken every
// clock while the pipe is not stalled. The depth is set by the bit-per-stage
// square root (24 stages) and the bit-per-stage fraction divider (FRAC_BITS
// + 1 stages), plus the input, square, sum, band select, blend multiply and
// output registers. Speed mode takes floor(sqrt(vx^2 + vy^2)) and picks one
// of three bands; density mode compares particle density with the target
// register. Both then divide to a Q1.FRAC_BITS fraction and blend two fixed
// colors. A stall on the output while a word is valid there freezes the
// whole pipe, and o_stall follows it; configuration is meant to be written
// only while the pipe is empty.
// ---------------------------------------------------------------------------
module particle_color_map_top #(
    parameter int FRAC_BITS = pcm_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [pcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcm_pkg::DENS_W-1:0]    i_cfg_data,
    // input words
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [pcm_pkg::VEL_W-1:0] i_vel_x,
    input  logic signed [pcm_pkg::VEL_W-1:0] i_vel_y,
    input  logic [pcm_pkg::DENS_W-1:0]    i_particle_density,
    // output words
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pcm_pkg::CH_W-1:0]      o_red,
    output logic [pcm_pkg::CH_W-1:0]      o_green,
    output logic [pcm_pkg::CH_W-1:0]      o_blue
);

    localparam int VW = pcm_pkg::VEL_W;
    localparam int DW = pcm_pkg::DENS_W;
    localparam int QW = FRAC_BITS + 1;
    localparam int PW = QW + 10;

    // configuration registers
    logic          r_mode;
    logic [DW-1:0] r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_target <= DW'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcm_pkg::CFG_MODE:   r_mode   <= i_cfg_data[0];
                pcm_pkg::CFG_TARGET: r_target <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe advances unless the output word is held
    logic en;
    logic r_f_valid;
    assign en      = !(r_f_valid && i_stall);
    assign o_stall = !en;

    // stage a: velocity magnitudes
    logic          r_a_valid;
    logic [VW-1:0] r_a_mx, r_a_my;
    logic [DW-1:0] r_a_dens;
    logic [VW-1:0] n_mx, n_my;

    always_comb begin
        n_mx = i_vel_x[VW-1] ? VW'(-i_vel_x) : i_vel_x;
        n_my = i_vel_y[VW-1] ? VW'(-i_vel_y) : i_vel_y;
    end

    // stage b: squares, stage c: sum of squares
    logic                    r_b_valid, r_c_valid;
    logic [pcm_pkg::SQ_W-1:0] r_b_sqx, r_b_sqy, r_c_sum;
    logic [DW-1:0]           r_b_dens, r_c_dens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
        if (en) begin
            r_a_mx   <= n_mx;
            r_a_my   <= n_my;
            r_a_dens <= i_particle_density;
            r_b_sqx  <= r_a_mx * r_a_mx;
            r_b_sqy  <= r_a_my * r_a_my;
            r_b_dens <= r_a_dens;
            r_c_sum  <= r_b_sqx + r_b_sqy;
            r_c_dens <= r_b_dens;
        end
    end

    // square root, density rides along
    logic                      sq_valid;
    logic [pcm_pkg::ROOT_W-1:0] sq_root;
    logic [DW-1:0]             sq_dens;

    pcm_sqrt_pipe #(
        .SIDE_W (DW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_valid),
        .i_rad   (r_c_sum),
        .i_side  (r_c_dens),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_dens)
    );

    // stage d: pick band or ramp, numerator and divisor
    logic                        r_d_valid;
    logic [DW-1:0]               r_d_num, r_d_den;
    logic [pcm_pkg::RAMP_W-1:0]  r_d_ramp;
    logic [DW-1:0]               n_num, n_den;
    logic [pcm_pkg::RAMP_W-1:0]  n_ramp;
    logic [pcm_pkg::ROOT_W-1:0]  over;

    always_comb begin
        over = sq_root - pcm_pkg::SPEED_400;
        if (!r_mode) begin
            if (sq_root < pcm_pkg::SPEED_100) begin
                n_num  = DW'(sq_root);
                n_den  = DW'(pcm_pkg::SPEED_100);
                n_ramp = pcm_pkg::RAMP_SLOW;
            end else if (sq_root <= pcm_pkg::SPEED_400) begin
                n_num  = DW'(sq_root - pcm_pkg::SPEED_100);
                n_den  = DW'(pcm_pkg::SPEED_300);
                n_ramp = pcm_pkg::RAMP_MID;
            end else if (over >= pcm_pkg::SPEED_400) begin
                // fraction saturates at one
                n_num  = DW'(1);
                n_den  = DW'(1);
                n_ramp = pcm_pkg::RAMP_FAST;
            end else begin
                n_num  = DW'(over);
                n_den  = DW'(pcm_pkg::SPEED_400);
                n_ramp = pcm_pkg::RAMP_FAST;
            end
        end else begin
            if (r_target == '0) begin
                // zero target acts as infinite ratio: plain brown
                n_num  = '0;
                n_den  = DW'(1);
                n_ramp = pcm_pkg::RAMP_BROWN;
            end else if (sq_dens < r_target) begin
                n_num  = sq_dens;
                n_den  = r_target;
                n_ramp = pcm_pkg::RAMP_SAND;
            end else begin
                n_num  = r_target;
                n_den  = sq_dens;
                n_ramp = pcm_pkg::RAMP_BROWN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= sq_valid;
        end
        if (en) begin
            r_d_num  <= n_num;
            r_d_den  <= n_den;
            r_d_ramp <= n_ramp;
        end
    end

    // fraction divider
    logic                       dv_valid;
    logic [QW-1:0]              dv_quot;
    logic [pcm_pkg::RAMP_W-1:0] dv_ramp;

    pcm_div_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (pcm_pkg::RAMP_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_valid),
        .i_num   (r_d_num),
        .i_den   (r_d_den),
        .i_side  (r_d_ramp),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_ramp)
    );

    // stage e: (hi - lo) * t per channel
    pcm_pkg::t_ramp      ramp;
    logic signed [8:0]   diff_r, diff_g, diff_b;
    logic signed [QW:0]  t_s;
    logic                r_e_valid;
    pcm_pkg::t_rgb       r_e_lo;
    logic signed [PW-1:0] r_e_pr, r_e_pg, r_e_pb;

    always_comb begin
        ramp   = pcm_pkg::ramp_colors(dv_ramp);
        diff_r = $signed({1'b0, ramp.hi.r}) - $signed({1'b0, ramp.lo.r});
        diff_g = $signed({1'b0, ramp.hi.g}) - $signed({1'b0, ramp.lo.g});
        diff_b = $signed({1'b0, ramp.hi.b}) - $signed({1'b0, ramp.lo.b});
        t_s    = $signed({1'b0, dv_quot});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= dv_valid;
        end
        if (en) begin
            r_e_lo <= ramp.lo;
            r_e_pr <= PW'(diff_r * t_s);
            r_e_pg <= PW'(diff_g * t_s);
            r_e_pb <= PW'(diff_b * t_s);
        end
    end

    // stage f: lo + floor(product / 2^FRAC_BITS), output register
    logic signed [PW-1:0] sum_r, sum_g, sum_b;
    pcm_pkg::t_rgb        r_f_rgb;

    always_comb begin
        sum_r = $signed({{(PW-8){1'b0}}, r_e_lo.r}) + (r_e_pr >>> FRAC_BITS);
        sum_g = $signed({{(PW-8){1'b0}}, r_e_lo.g}) + (r_e_pg >>> FRAC_BITS);
        sum_b = $signed({{(PW-8){1'b0}}, r_e_lo.b}) + (r_e_pb >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
        if (en) begin
            r_f_rgb.r <= sum_r[7:0];
            r_f_rgb.g <= sum_g[7:0];
            r_f_rgb.b <= sum_b[7:0];
        end
    end

    assign o_valid = r_f_valid;
    assign o_red   = r_f_rgb.r;
    assign o_green = r_f_rgb.g;
    assign o_blue  = r_f_rgb.b;

endmodule
